FILE: src/vhfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Video header field parser package
// Phase codes, controller states and command/status types.
// ----------------------------------------------------------------------------
package vhfp_pkg;

  typedef enum logic [5:0] {
    PH_SEARCH = 6'd0, PH_DONE = 6'd1,
    A_NAL = 6'd2, A_PROFILE = 6'd3, A_CONSTR = 6'd4, A_SPSID = 6'd5, A_CHROMA = 6'd6,
    A_SEPCOL = 6'd7, A_DEPTHL = 6'd8, A_DEPTHC = 6'd9, A_BYPASS = 6'd10,
    A_SCALING = 6'd11, A_LOG2FN = 6'd12, A_POCTYPE = 6'd13, A_POCLSB = 6'd14,
    A_DELTAZ = 6'd15, A_OFFNR = 6'd16, A_OFFTB = 6'd17, A_CYCLE = 6'd18,
    A_OFFREF = 6'd19, A_MAXREF = 6'd20, A_GAPS = 6'd21, A_FIRSTMB = 6'd22,
    A_STYPE = 6'd23, A_PPS = 6'd24, A_FNUM = 6'd25, A_OVR = 6'd26, A_NUMREF = 6'd27,
    A_MODFLAG = 6'd28, A_IDC = 6'd29, A_ABSDIFF = 6'd30, A_SKIPNUM = 6'd31,
    B_NAL = 6'd32, B_FIXED = 6'd33, B_SPSID = 6'd34, B_CHROMA = 6'd35,
    B_SEPCOL = 6'd36, B_WIDTH = 6'd37, B_HEIGHT = 6'd38, B_CONF = 6'd39,
    B_CONFOFF = 6'd40, B_DEPTHL = 6'd41, B_DEPTHC = 6'd42, B_LOG2POC = 6'd43,
    B_FIRST = 6'd44, B_NOOUT = 6'd45, B_PPS = 6'd46, B_ADDR = 6'd47,
    B_STYPE = 6'd48, B_POC = 6'd49, B_STSPS = 6'd50, B_NEG = 6'd51, B_POS = 6'd52,
    B_DELTA = 6'd53, B_USED = 6'd54
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE, ST_BITS, ST_FLUSH, ST_OUT
  } ctrl_state_e;

  localparam logic [1:0] CLASS_P = 2'd0;
  localparam logic [1:0] CLASS_I = 2'd1;
  localparam logic [1:0] CLASS_NONE = 2'd2;
  localparam logic [7:0] ADDR_CODEC = 8'd0;

  typedef struct packed {
    logic start;   // open a buffer with the accepted word
    logic load;    // take a word (search or bit window)
    logic bit_en;  // consume one bit from the window
    logic flush;   // consume a zero bit past the end
    logic close;   // result delivered
  } cmd_t;

  typedef struct packed {
    logic bits_left;  // bits remain in the loaded word
    logic done;       // parse finished
    logic searching;  // in start code search
  } sts_t;

endpackage

FILE: src/vhfp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Video header field parser channels
// Valid/ready interfaces for input words and result words.
// ----------------------------------------------------------------------------
interface vhfp_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, kind, data_byte, last_byte, input ready);
  modport sink (input valid, kind, data_byte, last_byte, output ready);
endinterface

interface vhfp_out_if;
  logic        valid;
  logic        ready;
  logic        parse_ok;
  logic [1:0]  slice_class;
  logic [15:0] reference_index;
  logic        drift_safe;
  modport source (output valid, parse_ok, slice_class, reference_index, drift_safe,
                  input ready);
  modport sink (input valid, parse_ok, slice_class, reference_index, drift_safe,
                output ready);
endinterface

FILE: src/vhfp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Video header field parser datapath
// Start code search, emulation removal and one-bit-per-cycle field decoding.
// ----------------------------------------------------------------------------
module vhfp_datapath #(
  parameter int GOLOMB_WIDTH = 32,
  parameter int SKIP_LIMIT   = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  vhfp_pkg::cmd_t  cmd_i,
  input  logic            kind_i,
  input  logic [7:0]      data_byte_i,
  input  logic            codec_i,
  output vhfp_pkg::sts_t  sts_o,
  output logic            parse_ok_o,
  output logic [1:0]      slice_class_o,
  output logic [15:0]     reference_index_o,
  output logic            drift_safe_o
);
  import vhfp_pkg::*;

  localparam int GZW = $clog2(GOLOMB_WIDTH + 1);
  localparam logic [7:0] SKIP_END = 8'(SKIP_LIMIT + 4);

  phase_e      phase_q, phase_d;
  logic [31:0] win_q, win_d;
  logic [7:0]  skip_q, skip_d;
  logic [1:0]  zrun_q, zrun_d;
  logic [GZW-1:0] gz_q, gz_d;
  logic [31:0] acc_q, acc_d;
  logic [7:0]  loop_q, loop_d;
  logic [3:0]  fnb_q, fnb_d, plb_q, plb_d;
  logic        extv_q, extv_d, gaps_q, gaps_d;
  logic        kind_q, kind_d, bcodec_q, bcodec_d;
  logic        rdg_q, rdg_d, rds_q, rds_d;
  logic [6:0]  left_q, left_d;
  logic        hip_q, hip_d, idr_q, idr_d, fseg_q, fseg_d;
  logic [4:0]  lidx_q, lidx_d;
  logic [1:0]  cmdc_q, cmdc_d;
  logic        ok_q, ok_d;
  logic [1:0]  cls_q, cls_d;
  logic [31:0] ref_q, ref_d;
  logic [7:0]  sh_q, sh_d;
  logic [3:0]  nb_q, nb_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEARCH; win_q <= '1; skip_q <= '0; zrun_q <= '0; gz_q <= '0;
      acc_q <= '0; loop_q <= '0; fnb_q <= '0; plb_q <= '0; extv_q <= 1'b0;
      gaps_q <= 1'b0; kind_q <= 1'b0; bcodec_q <= 1'b0; rdg_q <= 1'b0; rds_q <= 1'b0;
      left_q <= '0; hip_q <= 1'b0; idr_q <= 1'b0; fseg_q <= 1'b0; lidx_q <= '0;
      cmdc_q <= '0; ok_q <= 1'b0; cls_q <= CLASS_NONE; ref_q <= '0; sh_q <= '0;
      nb_q <= '0;
    end else begin
      phase_q <= phase_d; win_q <= win_d; skip_q <= skip_d; zrun_q <= zrun_d;
      gz_q <= gz_d; acc_q <= acc_d; loop_q <= loop_d; fnb_q <= fnb_d; plb_q <= plb_d;
      extv_q <= extv_d; gaps_q <= gaps_d; kind_q <= kind_d; bcodec_q <= bcodec_d;
      rdg_q <= rdg_d; rds_q <= rds_d; left_q <= left_d; hip_q <= hip_d;
      idr_q <= idr_d; fseg_q <= fseg_d; lidx_q <= lidx_d; cmdc_q <= cmdc_d;
      ok_q <= ok_d; cls_q <= cls_d; ref_q <= ref_d; sh_q <= sh_d; nb_q <= nb_d;
    end
  end

  logic [31:0] v;
  logic        adv, b;
  logic [31:0] acc_n;
  logic [7:0]  t264;
  logic [5:0]  t265;

  always_comb begin
    phase_d = phase_q; win_d = win_q; skip_d = skip_q; zrun_d = zrun_q; gz_d = gz_q;
    acc_d = acc_q; loop_d = loop_q; fnb_d = fnb_q; plb_d = plb_q; extv_d = extv_q;
    gaps_d = gaps_q; kind_d = kind_q; bcodec_d = bcodec_q; rdg_d = rdg_q;
    rds_d = rds_q; left_d = left_q; hip_d = hip_q; idr_d = idr_q; fseg_d = fseg_q;
    lidx_d = lidx_q; cmdc_d = cmdc_q; ok_d = ok_q; cls_d = cls_q; ref_d = ref_q;
    sh_d = sh_q; nb_d = nb_q;
    v = '0; adv = 1'b0; acc_n = '0;
    b = cmd_i.flush ? 1'b0 : sh_q[7];
    t264 = {3'd0, v[4:0]};
    t265 = '0;

    if (cmd_i.start) begin
      kind_d = kind_i; bcodec_d = codec_i; phase_d = PH_SEARCH; win_d = '1;
      skip_d = '0; zrun_d = '0; ok_d = 1'b0; cls_d = CLASS_NONE; ref_d = '0;
      if (!kind_i) begin
        if (!codec_i) begin
          fnb_d = '0; extv_d = 1'b0; gaps_d = 1'b0;
        end else begin
          plb_d = '0;
        end
      end
    end

    if (cmd_i.load) begin
      nb_d = '0;
      if (phase_d == PH_SEARCH) begin
        win_d = {win_d[23:0], data_byte_i};
        if (skip_d != 8'd255) skip_d = skip_d + 8'd1;
        if (win_d == 32'd1) begin
          zrun_d = '0; rdg_d = 1'b0; acc_d = '0;
          if (!bcodec_d) begin
            phase_d = A_NAL; left_d = 7'd8;
          end else begin
            phase_d = B_NAL; left_d = 7'd16;
          end
        end else if (skip_d >= SKIP_END) begin
          phase_d = PH_DONE; ok_d = 1'b0; cls_d = CLASS_NONE; ref_d = '0;
        end
      end else if (phase_d != PH_DONE) begin
        if (zrun_d == 2'd2 && data_byte_i == 8'd3) begin
          zrun_d = '0;
        end else begin
          zrun_d = (data_byte_i != 8'd0) ? 2'd0 : (zrun_d < 2'd2 ? zrun_d + 2'd1 : 2'd2);
          sh_d = data_byte_i; nb_d = 4'd8;
        end
      end
    end

    if (cmd_i.bit_en || cmd_i.flush) begin
      if (cmd_i.bit_en) begin
        sh_d = {sh_q[6:0], 1'b0}; nb_d = nb_q - 4'd1;
      end
      if (rdg_q && !rds_q) begin
        if (!b) begin
          gz_d = gz_q + GZW'(1);
          if (gz_d >= GZW'(GOLOMB_WIDTH)) begin
            adv = 1'b1;
            v = (GOLOMB_WIDTH >= 32) ? '1 : 32'((64'd1 << GOLOMB_WIDTH) - 64'd1);
          end
        end else if (gz_q == '0) begin
          adv = 1'b1; v = '0;
        end else begin
          rds_d = 1'b1; left_d = 7'(gz_q); acc_d = '0;
        end
      end else begin
        acc_n = {acc_q[30:0], b};
        acc_d = acc_n;
        if (left_q != '0) left_d = left_q - 7'd1;
        if (left_d == '0) begin
          adv = 1'b1;
          if (rdg_q) v = ((32'd1 << gz_q) - 32'd1) + acc_n;
          else v = acc_n;
        end
      end
    end

    if (adv) begin
      t264 = {3'd0, v[4:0]};
      t265 = v[14:9];
      unique case (phase_q)
        A_NAL: begin
          if (!kind_q) begin
            if (t264 != 8'd7) begin phase_d = PH_DONE; ok_d = 1'b0; end
            else begin phase_d = A_PROFILE; rdg_d = 1'b0; left_d = 7'd8; acc_d = '0; end
          end else if (t264 != 8'd1 && t264 != 8'd5) begin
            phase_d = PH_DONE; ok_d = 1'b0;
          end else begin
            idr_d = (t264 == 8'd5); ref_d = '0;
            phase_d = A_FIRSTMB; rdg_d = 1'b1; rds_d = 1'b0; gz_d = '0; acc_d = '0;
          end
        end
        A_PROFILE: begin
          hip_d = (v == 100 || v == 110 || v == 122 || v == 244 || v == 44 || v == 83 ||
                   v == 86 || v == 118 || v == 128 || v == 138 || v == 139 ||
                   v == 134 || v == 135);
          phase_d = A_CONSTR; rdg_d = 1'b0; left_d = 7'd16; acc_d = '0;
        end
        A_CONSTR: begin phase_d = A_SPSID; rdg_d = 1'b1; end
        A_SPSID: begin phase_d = hip_q ? A_CHROMA : A_LOG2FN; rdg_d = 1'b1; end
        A_CHROMA: begin
          if (v == 3) begin phase_d = A_SEPCOL; rdg_d = 1'b0; left_d = 7'd1; end
          else begin phase_d = A_DEPTHL; rdg_d = 1'b1; end
        end
        A_SEPCOL: begin phase_d = A_DEPTHL; rdg_d = 1'b1; end
        A_DEPTHL: begin phase_d = A_DEPTHC; rdg_d = 1'b1; end
        A_DEPTHC: begin phase_d = A_BYPASS; rdg_d = 1'b0; left_d = 7'd1; end
        A_BYPASS: begin phase_d = A_SCALING; rdg_d = 1'b0; left_d = 7'd1; end
        A_SCALING: begin
          if (v != 0) begin phase_d = PH_DONE; ok_d = 1'b0; end
          else begin phase_d = A_LOG2FN; rdg_d = 1'b1; end
        end
        A_LOG2FN: begin
          if (v > 12) begin phase_d = PH_DONE; ok_d = 1'b0; end
          else begin
            fnb_d = v[3:0]; extv_d = 1'b0; phase_d = A_POCTYPE; rdg_d = 1'b1;
          end
        end
        A_POCTYPE: begin
          if (v > 2) begin phase_d = PH_DONE; ok_d = 1'b1; end
          else if (v == 0) begin phase_d = A_POCLSB; rdg_d = 1'b1; end
          else if (v == 1) begin phase_d = A_DELTAZ; rdg_d = 1'b0; left_d = 7'd1; end
          else begin phase_d = A_MAXREF; rdg_d = 1'b1; end
        end
        A_POCLSB: begin phase_d = A_MAXREF; rdg_d = 1'b1; end
        A_DELTAZ: begin phase_d = A_OFFNR; rdg_d = 1'b1; end
        A_OFFNR: begin phase_d = A_OFFTB; rdg_d = 1'b1; end
        A_OFFTB: begin phase_d = A_CYCLE; rdg_d = 1'b1; end
        A_CYCLE: begin
          if (v > 255) begin phase_d = PH_DONE; ok_d = 1'b1; end
          else begin
            loop_d = v[7:0]; rdg_d = 1'b1;
            phase_d = (v[7:0] != 0) ? A_OFFREF : A_MAXREF;
          end
        end
        A_OFFREF: begin
          loop_d = loop_q - 8'd1; rdg_d = 1'b1;
          phase_d = (loop_d != 0) ? A_OFFREF : A_MAXREF;
        end
        A_MAXREF: begin
          if (v > 16) begin phase_d = PH_DONE; ok_d = 1'b1; end
          else begin phase_d = A_GAPS; rdg_d = 1'b0; left_d = 7'd1; end
        end
        A_GAPS: begin gaps_d = v[0]; extv_d = 1'b1; phase_d = PH_DONE; ok_d = 1'b1; end
        A_FIRSTMB: begin phase_d = A_STYPE; rdg_d = 1'b1; end
        A_STYPE: begin
          cls_d = (v == 0 || v == 5) ? CLASS_P : (v == 2 || v == 7) ? CLASS_I : CLASS_NONE;
          if (idr_q) begin phase_d = PH_DONE; ok_d = 1'b1; end
          else begin phase_d = A_PPS; rdg_d = 1'b1; end
        end
        A_PPS: begin phase_d = A_FNUM; rdg_d = 1'b0; left_d = 7'(fnb_q) + 7'd4; end
        A_FNUM: begin phase_d = A_OVR; rdg_d = 1'b0; left_d = 7'd1; end
        A_OVR: begin
          if (v != 0) begin phase_d = A_NUMREF; rdg_d = 1'b1; end
          else begin phase_d = A_MODFLAG; rdg_d = 1'b0; left_d = 7'd1; end
        end
        A_NUMREF: begin phase_d = A_MODFLAG; rdg_d = 1'b0; left_d = 7'd1; end
        A_MODFLAG: begin
          if (v == 0) begin phase_d = PH_DONE; ok_d = 1'b1; end
          else begin cmdc_d = '0; phase_d = A_IDC; rdg_d = 1'b1; end
        end
        A_IDC: begin
          if (cmdc_q == 2'd3 || v > 3) begin phase_d = PH_DONE; ok_d = 1'b0; end
          else if (v == 3) begin phase_d = PH_DONE; ok_d = 1'b1; end
          else begin phase_d = (v == 0) ? A_ABSDIFF : A_SKIPNUM; rdg_d = 1'b1; end
        end
        A_ABSDIFF: begin
          ref_d = v; cmdc_d = cmdc_q + 2'd1; phase_d = A_IDC; rdg_d = 1'b1;
        end
        A_SKIPNUM: begin cmdc_d = cmdc_q + 2'd1; phase_d = A_IDC; rdg_d = 1'b1; end
        B_NAL: begin
          if (!kind_q) begin
            if (t265 == 6'd32) begin
              phase_d = PH_SEARCH; win_d = '1; skip_d = '0;
            end else if (t265 != 6'd33) begin
              phase_d = PH_DONE; ok_d = 1'b0;
            end else begin
              phase_d = B_FIXED; rdg_d = 1'b0; left_d = 7'd104;
            end
          end else if (t265 != 6'd1 && t265 != 6'd20) begin
            phase_d = PH_DONE; ok_d = 1'b0;
          end else begin
            idr_d = (t265 == 6'd20); ref_d = 32'd255;
            phase_d = B_FIRST; rdg_d = 1'b0; left_d = 7'd1;
          end
        end
        B_FIXED: begin phase_d = B_SPSID; rdg_d = 1'b1; end
        B_SPSID: begin phase_d = B_CHROMA; rdg_d = 1'b1; end
        B_CHROMA: begin
          if (v == 3) begin phase_d = B_SEPCOL; rdg_d = 1'b0; left_d = 7'd1; end
          else begin phase_d = B_WIDTH; rdg_d = 1'b1; end
        end
        B_SEPCOL: begin phase_d = B_WIDTH; rdg_d = 1'b1; end
        B_WIDTH: begin phase_d = B_HEIGHT; rdg_d = 1'b1; end
        B_HEIGHT: begin phase_d = B_CONF; rdg_d = 1'b0; left_d = 7'd1; end
        B_CONF: begin
          rdg_d = 1'b1;
          if (v != 0) begin loop_d = 8'd4; phase_d = B_CONFOFF; end
          else phase_d = B_DEPTHL;
        end
        B_CONFOFF: begin
          loop_d = loop_q - 8'd1; rdg_d = 1'b1;
          phase_d = (loop_d != 0) ? B_CONFOFF : B_DEPTHL;
        end
        B_DEPTHL: begin phase_d = B_DEPTHC; rdg_d = 1'b1; end
        B_DEPTHC: begin phase_d = B_LOG2POC; rdg_d = 1'b1; end
        B_LOG2POC: begin
          if (v > 12) begin phase_d = PH_DONE; ok_d = 1'b0; end
          else begin plb_d = v[3:0]; phase_d = PH_DONE; ok_d = 1'b1; end
        end
        B_FIRST: begin
          fseg_d = (v != 0);
          if (idr_q) begin phase_d = B_NOOUT; rdg_d = 1'b0; left_d = 7'd1; end
          else begin phase_d = B_PPS; rdg_d = 1'b1; end
        end
        B_NOOUT: begin phase_d = B_PPS; rdg_d = 1'b1; end
        B_PPS: begin phase_d = fseg_q ? B_STYPE : B_ADDR; rdg_d = 1'b1; end
        B_ADDR: begin phase_d = B_STYPE; rdg_d = 1'b1; end
        B_STYPE: begin
          cls_d = (v == 1) ? CLASS_P : (v == 2) ? CLASS_I : CLASS_NONE;
          if (idr_q) begin phase_d = PH_DONE; ok_d = 1'b1; end
          else begin phase_d = B_POC; rdg_d = 1'b0; left_d = 7'(plb_q) + 7'd4; end
        end
        B_POC: begin phase_d = B_STSPS; rdg_d = 1'b0; left_d = 7'd1; end
        B_STSPS: begin
          if (v != 0) begin phase_d = PH_DONE; ok_d = 1'b1; end
          else begin phase_d = B_NEG; rdg_d = 1'b1; end
        end
        B_NEG: begin
          if (v > 16) begin phase_d = PH_DONE; ok_d = 1'b0; end
          else begin loop_d = v[7:0]; lidx_d = '0; phase_d = B_POS; rdg_d = 1'b1; end
        end
        B_POS: begin
          if (loop_q == 0) begin phase_d = PH_DONE; ok_d = 1'b1; end
          else begin phase_d = B_DELTA; rdg_d = 1'b1; end
        end
        B_DELTA: begin phase_d = B_USED; rdg_d = 1'b0; left_d = 7'd1; end
        B_USED: begin
          if (v != 0) begin
            ref_d = 32'(lidx_q); phase_d = PH_DONE; ok_d = 1'b1;
          end else begin
            lidx_d = lidx_q + 5'd1;
            if (8'(lidx_d) >= loop_q) begin phase_d = PH_DONE; ok_d = 1'b1; end
            else begin phase_d = B_DELTA; rdg_d = 1'b1; end
          end
        end
        default: begin phase_d = PH_DONE; ok_d = 1'b0; end
      endcase
      if (rdg_d) begin rds_d = 1'b0; gz_d = '0; end
      if (phase_d != PH_SEARCH && phase_d != PH_DONE) acc_d = '0;
      if (phase_d == PH_DONE && !ok_d) begin cls_d = CLASS_NONE; ref_d = '0; end
      if (phase_d == PH_DONE || phase_d == PH_SEARCH) nb_d = '0;
    end

    if (cmd_i.flush && phase_q == PH_SEARCH) begin
      phase_d = PH_DONE; ok_d = 1'b0; cls_d = CLASS_NONE; ref_d = '0;
    end
    if (cmd_i.close) phase_d = PH_SEARCH;
  end

  assign sts_o.bits_left = (nb_q != '0);
  assign sts_o.done = (phase_q == PH_DONE);
  assign sts_o.searching = (phase_q == PH_SEARCH);

  assign parse_ok_o = ok_q;
  assign slice_class_o = kind_q ? cls_q : CLASS_NONE;
  assign reference_index_o = !kind_q ? 16'd0 : (ref_q > 32'd65535) ? 16'hffff : ref_q[15:0];
  assign drift_safe_o = !codec_i && extv_q && !gaps_q;
endmodule

FILE: src/vhfp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Video header field parser controller
// Sequences word loads, bit steps, end flush and result delivery.
// ----------------------------------------------------------------------------
module vhfp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_last_i,
  input  logic           out_ready_i,
  input  vhfp_pkg::sts_t sts_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  output vhfp_pkg::cmd_t cmd_o
);
  import vhfp_pkg::*;

  ctrl_state_e state_q, state_d;
  logic busy_q, busy_d, last_q, last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; busy_q <= 1'b0; last_q <= 1'b0;
    end else begin
      state_q <= state_d; busy_q <= busy_d; last_q <= last_d;
    end
  end

  always_comb begin
    state_d = state_q; busy_d = busy_q; last_d = last_q;
    cmd_o = '0; in_ready_o = 1'b0; out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = !busy_q; cmd_o.load = 1'b1; busy_d = 1'b1;
          last_d = in_last_i; state_d = ST_BITS;
        end
      end
      ST_BITS: begin
        if (sts_i.bits_left && !sts_i.done && !sts_i.searching) begin
          cmd_o.bit_en = 1'b1;
        end else begin
          state_d = last_q ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (sts_i.done) state_d = ST_OUT;
        else cmd_o.flush = 1'b1;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.close = 1'b1; busy_d = 1'b0; state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

FILE: src/video_header_field_parser.sv
`timescale 1ns / 1ps
// Flow: a word is loaded, its payload bits are decoded one at a time, and a closing step
// returns to idle. After the last word, zero bits are read past the end until the parse
// is done, and the result is then shown until taken.
// The parser takes no new word until it is through with the last one.
// Reset clears all parse state, stored widths and flags, and the codec register.
// ----------------------------------------------------------------------------
// Video header field parser
// Top level: APB register, controller and datapath.
// ----------------------------------------------------------------------------
module video_header_field_parser #(
  parameter int GOLOMB_WIDTH = 32,
  parameter int SKIP_LIMIT   = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  vhfp_in_if.sink     in_if,
  vhfp_out_if.source  out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import vhfp_pkg::*;

  logic codec_q;
  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codec_q <= 1'b0;
    end else if (psel && penable && pwrite && ({6'd0, paddr} == ADDR_CODEC)) begin
      codec_q <= pwdata[0];
    end
  end
  assign prdata = ({6'd0, paddr} == ADDR_CODEC) ? {31'd0, codec_q} : 32'd0;

  vhfp_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_if.valid),
    .in_last_i(in_if.last_byte), .out_ready_i(out_if.ready), .sts_i(sts),
    .in_ready_o(in_if.ready), .out_valid_o(out_if.valid), .cmd_o(cmd)
  );

  vhfp_datapath #(.GOLOMB_WIDTH(GOLOMB_WIDTH), .SKIP_LIMIT(SKIP_LIMIT)) u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd), .kind_i(in_if.kind),
    .data_byte_i(in_if.data_byte), .codec_i(codec_q), .sts_o(sts),
    .parse_ok_o(out_if.parse_ok), .slice_class_o(out_if.slice_class),
    .reference_index_o(out_if.reference_index), .drift_safe_o(out_if.drift_safe)
  );

`ifndef ASSERT_OFF
  a_no_in_during_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> !in_if.ready) else $error("input taken while result pending");
  a_out_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> sts.done) else $error("result shown before parse done");
  a_fail_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.parse_ok) |-> (out_if.slice_class == CLASS_NONE))
    else $error("failed parse with a slice class");
`endif
endmodule
